>>> rtl/pppon_pkg.sv
// ----------------------------------------------------------------------------
// PPP option negotiation package
// Shared types, codes and reset values of the option negotiation automaton.
// ----------------------------------------------------------------------------
package pppon_pkg;

  localparam int unsigned RetryBits = 8;

  localparam logic [7:0] MaxCfgReqRst  = 8'd10;
  localparam logic [7:0] MaxTermReqRst = 8'd2;
  localparam logic       ActiveOpenRst  = 1'b1;
  localparam logic       PassiveOpenRst = 1'b0;

  typedef enum logic [2:0] {
    StClosed   = 3'd0,
    StListen   = 3'd1,
    StReqSent  = 3'd2,
    StAckRcvd  = 3'd3,
    StAckSent  = 3'd4,
    StOpened   = 3'd5,
    StTermSent = 3'd6
  } link_state_e;

  typedef enum logic [2:0] {
    CmdPacket  = 3'd0,
    CmdTimeout = 3'd1,
    CmdOpen    = 3'd2,
    CmdDown    = 3'd3,
    CmdClose   = 3'd4,
    CmdReinit  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    TmLeave   = 2'd0,
    TmRestart = 2'd1,
    TmStop    = 2'd2
  } timer_e;

  typedef enum logic [1:0] {
    CfgMaxCfgReq  = 2'd0,
    CfgMaxTermReq = 2'd1,
    CfgActiveOpen = 2'd2,
    CfgPassiveOpen = 2'd3
  } cfg_idx_e;

  // received packet codes
  localparam logic [7:0] PktCfgReq   = 8'd1;
  localparam logic [7:0] PktCfgAck   = 8'd2;
  localparam logic [7:0] PktCfgNak   = 8'd3;
  localparam logic [7:0] PktCfgRej   = 8'd4;
  localparam logic [7:0] PktTermReq  = 8'd5;
  localparam logic [7:0] PktTermAck  = 8'd6;
  localparam logic [7:0] PktCodeRej  = 8'd7;
  localparam logic [7:0] PktProtRej  = 8'd8;
  localparam logic [7:0] PktEchoReq  = 8'd9;
  localparam logic [7:0] PktEchoRep  = 8'd10;
  localparam logic [7:0] PktDiscard  = 8'd11;
  localparam logic [7:0] PktQuality  = 8'd12;

  // transmitted packet codes
  localparam logic [3:0] SendNone     = 4'd0;
  localparam logic [3:0] SendCfgReq   = 4'd1;
  localparam logic [3:0] SendTermReq  = 4'd5;
  localparam logic [3:0] SendTermAck  = 4'd6;
  localparam logic [3:0] SendCodeRej  = 4'd7;
  localparam logic [3:0] SendEchoRep  = 4'd10;
  localparam logic [3:0] SendCodeMax  = 4'd11;

  typedef struct packed {
    logic [7:0] max_cfg_req;
    logic [7:0] max_term_req;
    logic       active_open;
    logic       passive_open;
  } cfg_t;

  typedef struct packed {
    logic [6:0] pad;
    logic       options_ok;
    logic [7:0] pkt_id;
    logic [7:0] pkt_code;
  } in_data_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic        options_reset;
    logic        layer_finished;
    logic        layer_started;
    logic        layer_down;
    logic        layer_up;
    timer_e      timer_action;
    link_state_e link_state;
    logic [7:0]  send_id;
    logic [3:0]  send_code;
  } out_data_t;

  localparam int unsigned InDataW  = $bits(in_data_t);
  localparam int unsigned OutDataW = $bits(out_data_t);

endpackage

>>> rtl/ppp_option_negotiation_fsm.sv
// ----------------------------------------------------------------------------
// PPP option negotiation automaton
// Seven-state option negotiation with listen state: one result item per
// event item, carrying the packet to send, new state, timer action and pulses.
//
//   channel   dir  handshake                   payload
//   s_        in   s_tvalid_i / s_tready_o     s_tuser_i cmd, s_tdata_i packet
//   m_        out  m_tvalid_o / m_tready_i     m_tdata_o result
//   cfg_      in   cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle while m_tready_i is not held low; an accepted item
// passes the input register and then the result register, with the
// state decode between them combinational.
// Reset loads the default configuration, listen state and ten retries.
// A stalled result holds in the result register; the input register still
// takes one more item, so the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module ppp_option_negotiation_fsm #(
  parameter int unsigned RETRY_BITS = pppon_pkg::RetryBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // pkt_code, pkt_id, options_ok
  input  logic [pppon_pkg::InDataW-1:0]   s_tdata_i,
  // cmd
  input  logic [2:0]                      s_tuser_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // send_code, send_id, link_state, timer_action, layer_up, layer_down,
  // layer_started, layer_finished, options_reset
  output logic [pppon_pkg::OutDataW-1:0]  m_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [7:0]                      cfg_data_i
);

  pppon_pkg::cfg_t      cfg;
  pppon_pkg::in_data_t  in_q;
  logic [2:0]           cmd_q;
  logic                 in_vld_d, in_vld_q;
  logic                 out_vld_d, out_vld_q;
  pppon_pkg::out_data_t out_q, res;
  logic                 s_acc, advance;

  assign cfg_ready_o = 1'b1;

  pppon_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  pppon_core #(
    .RETRY_BITS (RETRY_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd_q),
    .evt_i    (in_q),
    .commit_i (advance),
    .res_o    (res)
  );

  assign advance    = in_vld_q && (!out_vld_q || m_tready_i);
  assign s_tready_o = !in_vld_q || advance;
  assign s_acc      = s_tvalid_i && s_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_acc) in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
    out_vld_d = out_vld_q;
    if (advance) out_vld_d = 1'b1;
    else if (m_tready_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q  <= pppon_pkg::in_data_t'(s_tdata_i);
      cmd_q <= s_tuser_i;
    end
    if (advance) out_q <= res;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_q;

endmodule

>>> rtl/pppon_cfg.sv
// ----------------------------------------------------------------------------
// PPP option negotiation configuration registers
// Holds retry limits and open modes, written through the configuration port.
// ----------------------------------------------------------------------------
module pppon_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [1:0]        wr_index_i,
  input  logic [7:0]        wr_data_i,
  output pppon_pkg::cfg_t   cfg_o
);

  pppon_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (pppon_pkg::cfg_idx_e'(wr_index_i))
        pppon_pkg::CfgMaxCfgReq:   cfg_d.max_cfg_req  = wr_data_i;
        pppon_pkg::CfgMaxTermReq:  cfg_d.max_term_req = wr_data_i;
        pppon_pkg::CfgActiveOpen:  cfg_d.active_open  = wr_data_i[0];
        pppon_pkg::CfgPassiveOpen: cfg_d.passive_open = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_cfg_req  <= pppon_pkg::MaxCfgReqRst;
      cfg_q.max_term_req <= pppon_pkg::MaxTermReqRst;
      cfg_q.active_open  <= pppon_pkg::ActiveOpenRst;
      cfg_q.passive_open <= pppon_pkg::PassiveOpenRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/pppon_core.sv
// ----------------------------------------------------------------------------
// PPP option negotiation core
// Automaton state, retry count and request id with the per-event decode.
// ----------------------------------------------------------------------------
module pppon_core #(
  parameter int unsigned RETRY_BITS = pppon_pkg::RetryBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pppon_pkg::cfg_t       cfg_i,
  input  logic [2:0]            cmd_i,
  input  pppon_pkg::in_data_t   evt_i,
  input  logic                  commit_i,
  output pppon_pkg::out_data_t  res_o
);

  typedef logic [RETRY_BITS-1:0] retry_t;

  typedef struct packed {
    pppon_pkg::link_state_e st;
    retry_t                 ret;
    logic [7:0]             nid;
    pppon_pkg::out_data_t   res;
  } ctx_t;

  localparam pppon_pkg::link_state_e StRst =
    (pppon_pkg::ActiveOpenRst | pppon_pkg::PassiveOpenRst) ?
    pppon_pkg::StListen : pppon_pkg::StClosed;

  pppon_pkg::link_state_e st_q;
  retry_t                 ret_q;
  logic [7:0]             nid_q;
  ctx_t                   c;

  function automatic ctx_t auto_rst(ctx_t x, pppon_pkg::cfg_t cfg);
    ctx_t y;
    y = x;
    y.st = (cfg.active_open | cfg.passive_open) ? pppon_pkg::StListen : pppon_pkg::StClosed;
    y.ret = RETRY_BITS'(cfg.max_cfg_req);
    y.res.options_reset = 1'b1;
    return y;
  endfunction

  function automatic ctx_t send_req(ctx_t x, logic [3:0] code);
    ctx_t y;
    y = x;
    if (x.ret != '0) begin
      y.ret = x.ret - RETRY_BITS'(1);
      y.res.timer_action = pppon_pkg::TmRestart;
      y.res.send_code = code;
      y.res.send_id = x.nid;
      y.nid = x.nid + 8'd1;
    end
    return y;
  endfunction

  function automatic ctx_t go_opened(ctx_t x);
    ctx_t y;
    y = x;
    y.res.timer_action = pppon_pkg::TmStop;
    y.res.layer_up = 1'b1;
    y.st = pppon_pkg::StOpened;
    return y;
  endfunction

  function automatic ctx_t emit(ctx_t x, logic [3:0] code, logic [7:0] id);
    ctx_t y;
    y = x;
    y.res.send_code = code;
    y.res.send_id = id;
    return y;
  endfunction

  always_comb begin
    pppon_pkg::link_state_e s;
    logic ok;
    s = st_q;
    ok = evt_i.options_ok;
    c.st = st_q;
    c.ret = ret_q;
    c.nid = nid_q;
    c.res = '0;
    unique case (pppon_pkg::cmd_e'(cmd_i))
      pppon_pkg::CmdPacket: begin
        unique case (evt_i.pkt_code)
          pppon_pkg::PktCfgReq: begin
            if (s == pppon_pkg::StOpened || s == pppon_pkg::StListen ||
                s == pppon_pkg::StReqSent || s == pppon_pkg::StAckSent) begin
              if (s == pppon_pkg::StOpened) begin
                c.res.layer_down = 1'b1;
                c = auto_rst(c, cfg_i);
              end
              if (s == pppon_pkg::StOpened || s == pppon_pkg::StListen) begin
                c.res.layer_started = 1'b1;
                c = send_req(c, pppon_pkg::SendCfgReq);
              end
              c.st = ok ? pppon_pkg::StAckSent : pppon_pkg::StReqSent;
            end else if (s == pppon_pkg::StAckRcvd) begin
              if (ok) c = go_opened(c);
              else c.res.timer_action = pppon_pkg::TmRestart;
            end else if (s == pppon_pkg::StClosed) begin
              c = emit(c, pppon_pkg::SendTermAck, evt_i.pkt_id);
            end
          end
          pppon_pkg::PktCfgAck, pppon_pkg::PktCfgNak, pppon_pkg::PktCfgRej: begin
            if (s == pppon_pkg::StReqSent || s == pppon_pkg::StAckSent) begin
              if (evt_i.pkt_code == pppon_pkg::PktCfgAck) begin
                if (ok) begin
                  if (s == pppon_pkg::StReqSent) c.st = pppon_pkg::StAckRcvd;
                  else c = go_opened(c);
                end
              end else if (ok) begin
                c = send_req(c, pppon_pkg::SendCfgReq);
              end
            end else if (s == pppon_pkg::StOpened || s == pppon_pkg::StAckRcvd) begin
              if (s == pppon_pkg::StOpened) begin
                c.res.layer_down = 1'b1;
                c.res.layer_started = 1'b1;
                c = auto_rst(c, cfg_i);
              end
              c = send_req(c, pppon_pkg::SendCfgReq);
              c.st = pppon_pkg::StReqSent;
            end else if (s == pppon_pkg::StClosed || s == pppon_pkg::StListen) begin
              c = emit(c, pppon_pkg::SendTermAck, evt_i.pkt_id);
            end
          end
          pppon_pkg::PktTermReq: begin
            c = emit(c, pppon_pkg::SendTermAck, evt_i.pkt_id);
            if (s == pppon_pkg::StOpened) begin
              c.res.layer_down = 1'b1;
              c.res.layer_finished = 1'b1;
              c = auto_rst(c, cfg_i);
            end else if (s == pppon_pkg::StAckRcvd || s == pppon_pkg::StAckSent) begin
              c.st = pppon_pkg::StReqSent;
            end
          end
          pppon_pkg::PktTermAck: begin
            if (s == pppon_pkg::StTermSent) begin
              c.res.timer_action = pppon_pkg::TmStop;
              c.res.layer_finished = 1'b1;
              c = auto_rst(c, cfg_i);
            end else if (s == pppon_pkg::StOpened) begin
              c.res.layer_down = 1'b1;
              c = auto_rst(c, cfg_i);
              if (c.ret != '0) begin
                c = send_req(c, pppon_pkg::SendCfgReq);
                c.st = pppon_pkg::StReqSent;
              end
            end else if (s == pppon_pkg::StAckRcvd || s == pppon_pkg::StAckSent) begin
              c.st = pppon_pkg::StReqSent;
            end
          end
          pppon_pkg::PktCodeRej: begin
            c.res.layer_finished = 1'b1;
            c = auto_rst(c, cfg_i);
          end
          pppon_pkg::PktEchoReq: begin
            if (s == pppon_pkg::StOpened) begin
              c = emit(c, pppon_pkg::SendEchoRep, evt_i.pkt_id);
            end else if (s == pppon_pkg::StClosed || s == pppon_pkg::StListen) begin
              c = emit(c, pppon_pkg::SendTermAck, evt_i.pkt_id);
            end
          end
          pppon_pkg::PktProtRej, pppon_pkg::PktEchoRep,
          pppon_pkg::PktDiscard, pppon_pkg::PktQuality: ;
          default: begin
            c = emit(c, pppon_pkg::SendCodeRej, evt_i.pkt_id);
            if (s == pppon_pkg::StReqSent || s == pppon_pkg::StAckRcvd ||
                s == pppon_pkg::StAckSent || s == pppon_pkg::StOpened) begin
              c.st = pppon_pkg::StListen;
            end
          end
        endcase
      end
      pppon_pkg::CmdTimeout: begin
        if (s == pppon_pkg::StReqSent || s == pppon_pkg::StAckRcvd ||
            s == pppon_pkg::StAckSent) begin
          if (ret_q != '0) begin
            c = send_req(c, pppon_pkg::SendCfgReq);
            c.st = pppon_pkg::StReqSent;
          end else begin
            c = auto_rst(c, cfg_i);
          end
        end else if (s == pppon_pkg::StTermSent) begin
          if (ret_q != '0) begin
            c = send_req(c, pppon_pkg::SendTermReq);
          end else begin
            c.res.layer_finished = 1'b1;
            c = auto_rst(c, cfg_i);
          end
        end
      end
      pppon_pkg::CmdOpen: begin
        if ((cfg_i.active_open | cfg_i.passive_open) &&
            (s == pppon_pkg::StClosed || s == pppon_pkg::StListen ||
             s == pppon_pkg::StTermSent)) begin
          c.res.layer_started = 1'b1;
          c = auto_rst(c, cfg_i);
          if (cfg_i.active_open) begin
            c = send_req(c, pppon_pkg::SendCfgReq);
            c.st = pppon_pkg::StReqSent;
          end
        end
      end
      pppon_pkg::CmdDown: begin
        if (s == pppon_pkg::StReqSent || s == pppon_pkg::StAckRcvd ||
            s == pppon_pkg::StAckSent) begin
          c.res.timer_action = pppon_pkg::TmStop;
          c = auto_rst(c, cfg_i);
        end else if (s == pppon_pkg::StOpened) begin
          c.res.layer_down = 1'b1;
          c = auto_rst(c, cfg_i);
        end else if (s == pppon_pkg::StTermSent) begin
          c = auto_rst(c, cfg_i);
        end
      end
      pppon_pkg::CmdClose: begin
        if (s == pppon_pkg::StOpened || s == pppon_pkg::StAckSent) begin
          if (s == pppon_pkg::StOpened) c.res.layer_down = 1'b1;
          c.ret = RETRY_BITS'(cfg_i.max_term_req);
          c = send_req(c, pppon_pkg::SendTermReq);
          c.st = pppon_pkg::StTermSent;
        end else if (s == pppon_pkg::StReqSent || s == pppon_pkg::StAckRcvd) begin
          c.ret = '0;
          c.st = pppon_pkg::StTermSent;
        end else if (s == pppon_pkg::StListen) begin
          c.st = pppon_pkg::StClosed;
        end
      end
      pppon_pkg::CmdReinit: c = auto_rst(c, cfg_i);
      default: ;
    endcase
    c.res.link_state = c.st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StRst;
      ret_q <= RETRY_BITS'(pppon_pkg::MaxCfgReqRst);
      nid_q <= '0;
    end else if (commit_i) begin
      st_q  <= c.st;
      ret_q <= c.ret;
      nid_q <= c.nid;
    end
  end

  assign res_o = c.res;

endmodule

>>> rtl/pppon_chk.sv
// ----------------------------------------------------------------------------
// PPP option negotiation port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module pppon_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_tvalid_o,
  input logic                            m_tready_i,
  input logic [pppon_pkg::OutDataW-1:0]  m_tdata_o
);

  pppon_pkg::out_data_t r;
  assign r = pppon_pkg::out_data_t'(m_tdata_o);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> r.send_code <= pppon_pkg::SendCodeMax && r.pad == '0)
    else $error("bad send code");

  a_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && r.layer_up |->
      r.link_state == pppon_pkg::StOpened && r.timer_action == pppon_pkg::TmStop &&
      !r.options_reset)
    else $error("layer up without opened state");

  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && r.layer_finished |->
      r.options_reset &&
      (r.link_state == pppon_pkg::StListen || r.link_state == pppon_pkg::StClosed))
    else $error("layer finished without automaton reset");

endmodule

bind ppp_option_negotiation_fsm pppon_chk u_pppon_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o)
);
